@@ src/sls_pkg.sv @@
package sls_pkg;

  localparam int unsigned VALUE_WIDTH = 24;
  localparam int unsigned FRAC_Q      = VALUE_WIDTH - 4;
  localparam int unsigned FRAC_P      = VALUE_WIDTH - 8;
  localparam int unsigned SUM_WIDTH   = VALUE_WIDTH + 2;
  localparam int unsigned PROD_WIDTH  = 2 * VALUE_WIDTH + 2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic {
    K_PASS     = 1'b0,
    K_INTERIOR = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e  kind;
    logic   last;
    value_t left_re;
    value_t left_im;
    value_t mid_re;
    value_t mid_im;
    value_t right_re;
    value_t right_im;
    value_t old_re;
    value_t old_im;
    value_t pot;
  } entry_t;

  typedef struct packed {
    logic   valid0;
    logic   valid1;
    entry_t entry0;
    entry_t entry1;
  } push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              room2;
  } qstat_t;

endpackage

@@ src/sls_if.sv @@
interface sls_in_if;
  import sls_pkg::*;

  logic   valid;
  logic   ready;
  value_t cur_re;
  value_t cur_im;
  value_t old_re;
  value_t old_im;
  value_t reduced_pot;
  logic   last_point;

  modport source (
    output valid, cur_re, cur_im, old_re, old_im, reduced_pot, last_point,
    input  ready
  );
  modport sink (
    input  valid, cur_re, cur_im, old_re, old_im, reduced_pot, last_point,
    output ready
  );
endinterface

interface sls_out_if;
  import sls_pkg::*;

  logic   valid;
  logic   ready;
  value_t new_re;
  value_t new_im;
  logic   last_out;

  modport source (
    output valid, new_re, new_im, last_out,
    input  ready
  );
  modport sink (
    input  valid, new_re, new_im, last_out,
    output ready
  );
endinterface

@@ src/sls_front.sv @@
module sls_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  sls_in_if.sink          in_i,
  input  sls_pkg::qstat_t qstat_i,
  output sls_pkg::push_t  push_o
);
  import sls_pkg::*;

  logic   accept;
  logic   has_prev;
  logic [1:0] seen_q, seen_d;
  value_t win0_re_q, win0_im_q, win1_re_q, win1_im_q;
  value_t dold_re_q, dold_im_q, dpot_q;
  entry_t e_prev, e_last;

  assign in_i.ready = qstat_i.room2;
  assign accept     = in_i.valid && in_i.ready;
  assign has_prev   = (seen_q != 2'd0);

  always_comb begin
    e_prev          = '0;
    e_prev.kind     = (seen_q == 2'd1) ? K_PASS : K_INTERIOR;
    e_prev.last     = 1'b0;
    e_prev.left_re  = win0_re_q;
    e_prev.left_im  = win0_im_q;
    e_prev.mid_re   = win1_re_q;
    e_prev.mid_im   = win1_im_q;
    e_prev.right_re = in_i.cur_re;
    e_prev.right_im = in_i.cur_im;
    e_prev.old_re   = dold_re_q;
    e_prev.old_im   = dold_im_q;
    e_prev.pot      = dpot_q;

    e_last        = '0;
    e_last.kind   = K_PASS;
    e_last.last   = 1'b1;
    e_last.mid_re = in_i.cur_re;
    e_last.mid_im = in_i.cur_im;
  end

  always_comb begin
    push_o.valid0 = accept && (has_prev || in_i.last_point);
    push_o.entry0 = has_prev ? e_prev : e_last;
    push_o.valid1 = accept && has_prev && in_i.last_point;
    push_o.entry1 = e_last;
  end

  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      if (in_i.last_point) begin
        seen_d = 2'd0;
      end else if (seen_q != 2'd2) begin
        seen_d = seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
    end else begin
      seen_q <= seen_d;
    end
  end

  // shift the window on every accepted word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win0_re_q <= win1_re_q;
      win0_im_q <= win1_im_q;
      win1_re_q <= in_i.cur_re;
      win1_im_q <= in_i.cur_im;
      dold_re_q <= in_i.old_re;
      dold_im_q <= in_i.old_im;
      dpot_q    <= in_i.reduced_pot;
    end
  end

endmodule

@@ src/sls_fifo.sv @@
module sls_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sls_pkg::push_t   push_i,
  input  logic             pop_i,
  output sls_pkg::entry_t  head_o,
  output sls_pkg::qstat_t  qstat_o
);
  import sls_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] rd_q, rd_d, wr_q, wr_d, wr_nx;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  function automatic logic [QPTR_W-1:0] inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_nx  = inc(wr_q);
  assign do_pop = pop_i && (count_q != '0);
  assign head_o = mem_q[rd_q];

  always_comb begin
    qstat_o.count = count_q;
    qstat_o.empty = (count_q == '0);
    qstat_o.room2 = (count_q <= QCNT_W'(QDEPTH - 2));
  end

  always_comb begin
    rd_d    = do_pop ? inc(rd_q) : rd_q;
    wr_d    = wr_q;
    count_d = count_q - QCNT_W'(do_pop);
    if (push_i.valid0 && push_i.valid1) begin
      wr_d    = inc(wr_nx);
      count_d = count_d + QCNT_W'(2);
    end else if (push_i.valid0) begin
      wr_d    = wr_nx;
      count_d = count_d + QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) begin
      mem_q[wr_q] <= push_i.entry0;
    end
    if (push_i.valid1) begin
      mem_q[wr_nx] <= push_i.entry1;
    end
  end

endmodule

@@ src/sls_back.sv @@
module sls_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sls_pkg::value_t step_coeff_i,
  input  sls_pkg::entry_t head_i,
  input  sls_pkg::qstat_t qstat_i,
  output logic            pop_o,
  sls_out_if.source       out_o
);
  import sls_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_M0   = 6'b000010,
    B_M1   = 6'b000100,
    B_M2   = 6'b001000,
    B_M3   = 6'b010000,
    B_M4   = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;
  entry_t  work_q;

  logic signed [SUM_WIDTH-1:0]  s_i_q, s_r_q, b_op;
  logic signed [PROD_WIDTH-1:0] prod_q, mul_res;
  value_t                       t_i_q, a_op;
  value_t                       ld_re, ld_im;
  logic                         ld, ld_last, out_free;
  logic signed [VALUE_WIDTH:0]  diff_re, diff_im;

  logic   out_valid_q;
  value_t out_re_q, out_im_q;
  logic   out_last_q;

  function automatic value_t round_sat(input logic signed [PROD_WIDTH-1:0] p,
                                       input int unsigned sh);
    logic                neg;
    logic [PROD_WIDTH:0] m;
    logic [PROD_WIDTH:0] q;
    logic [PROD_WIDTH:0] lim;
    neg = p[PROD_WIDTH-1];
    m   = {p[PROD_WIDTH-1], p};
    if (neg) begin
      m = ~m + 1'b1;
    end
    q   = (m + ((PROD_WIDTH+1)'(1) << (sh - 1))) >> sh;
    lim = ((PROD_WIDTH+1)'(1) << (VALUE_WIDTH - 1)) - (PROD_WIDTH+1)'(!neg);
    if (q > lim) begin
      q = lim;
    end
    return neg ? -VALUE_WIDTH'(q) : VALUE_WIDTH'(q);
  endfunction

  function automatic value_t sat_w(input logic signed [VALUE_WIDTH:0] d);
    if (d[VALUE_WIDTH] != d[VALUE_WIDTH-1]) begin
      return d[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                            : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
    return d[VALUE_WIDTH-1:0];
  endfunction

  assign out_free = !out_valid_q || out_o.ready;
  assign mul_res  = PROD_WIDTH'(a_op) * PROD_WIDTH'(b_op);
  assign diff_re  = (VALUE_WIDTH+1)'(work_q.old_re) - (VALUE_WIDTH+1)'(t_i_q);
  assign diff_im  = (VALUE_WIDTH+1)'(work_q.old_im)
                  + (VALUE_WIDTH+1)'(round_sat(prod_q, FRAC_Q));

  // share one multiplier across the four products
  always_comb begin
    unique case (state_q)
      B_M0: begin
        a_op = work_q.pot;
        b_op = SUM_WIDTH'(work_q.mid_im);
      end
      B_M1: begin
        a_op = work_q.pot;
        b_op = SUM_WIDTH'(work_q.mid_re);
      end
      B_M2: begin
        a_op = step_coeff_i;
        b_op = s_i_q;
      end
      default: begin
        a_op = step_coeff_i;
        b_op = s_r_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    ld      = 1'b0;
    ld_re   = head_i.mid_re;
    ld_im   = head_i.mid_im;
    ld_last = head_i.last;
    unique case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          if (head_i.kind == K_PASS) begin
            if (out_free) begin
              ld    = 1'b1;
              pop_o = 1'b1;
            end
          end else begin
            pop_o   = 1'b1;
            state_d = B_M0;
          end
        end
      end
      B_M0: state_d = B_M1;
      B_M1: state_d = B_M2;
      B_M2: state_d = B_M3;
      B_M3: state_d = B_M4;
      B_M4: begin
        if (out_free) begin
          ld      = 1'b1;
          ld_re   = sat_w(diff_re);
          ld_im   = sat_w(diff_im);
          ld_last = work_q.last;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= ld || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && pop_o && head_i.kind == K_INTERIOR) begin
      work_q <= head_i;
    end
    if (state_q == B_M0 || state_q == B_M1 || state_q == B_M2 || state_q == B_M3) begin
      prod_q <= mul_res;
    end
    if (state_q == B_M1) begin
      s_i_q <= SUM_WIDTH'(work_q.left_im) + SUM_WIDTH'(work_q.right_im)
             - SUM_WIDTH'(round_sat(prod_q, FRAC_P));
    end
    if (state_q == B_M2) begin
      s_r_q <= SUM_WIDTH'(work_q.left_re) + SUM_WIDTH'(work_q.right_re)
             - SUM_WIDTH'(round_sat(prod_q, FRAC_P));
    end
    if (state_q == B_M3) begin
      t_i_q <= round_sat(prod_q, FRAC_Q);
    end
    if (ld) begin
      out_re_q   <= ld_re;
      out_im_q   <= ld_im;
      out_last_q <= ld_last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.new_re   = out_re_q;
  assign out_o.new_im   = out_im_q;
  assign out_o.last_out = out_last_q;

endmodule

@@ src/schrodinger_leapfrog_stencil.sv @@
// Leapfrog step of the 1-D Schrodinger wave function, one grid point per input word, in signed
// Q4.20 (potential Q8.16). The front end takes a word whenever the four-entry result queue
// has room for two entries, so words enter back to back until three entries wait there.
// Each result lags its point by one word; the word marked last_point flushes two. A boundary
// result at the queue head is loaded into the output register once that register is free;
// an interior point is popped and then steps through states M0 to M4, as its four products
// run in turn on the single shared 24 x 26 multiplier, and the back end takes no new entry
// until its result is loaded. The user must write step_coeff through cfg_we_i / cfg_data_i
// only while the block is idle, which the block itself does not enforce; it resets to zero.
module schrodinger_leapfrog_stencil (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  sls_pkg::value_t cfg_data_i,
  sls_in_if.sink          in_i,
  sls_out_if.source       out_o
);
  import sls_pkg::*;

  value_t step_coeff_q;
  push_t  push;
  entry_t head;
  qstat_t qstat;
  logic   pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_coeff_q <= '0;
    end else if (cfg_we_i) begin
      step_coeff_q <= cfg_data_i;
    end
  end

  sls_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .qstat_i (qstat),
    .push_o  (push)
  );

  sls_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  sls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_coeff_i (step_coeff_q),
    .head_i       (head),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_o        (out_o)
  );

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_last_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.last_point |=> qstat.count != '0)
    else $error("last point word left no queued result");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty result queue");
`endif

endmodule
